// File: sv/index_remap_after_edits_defines.svh
// Assertion helpers for the index remap block.
`ifndef INDEX_REMAP_AFTER_EDITS_DEFINES_SVH
`define INDEX_REMAP_AFTER_EDITS_DEFINES_SVH

// Same-cycle implication.
`define IRAE_ASSERT_SAME(label, clk, rst, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error(msg);

// Next-cycle implication.
`define IRAE_ASSERT_NEXT(label, clk, rst, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error(msg);

`endif

// File: sv/irae_pkg.sv
package irae_pkg;

  localparam int WORD_W            = 32;
  localparam int BIT_W             = $clog2(WORD_W);
  localparam int POS_W             = 10;
  localparam int OUT_W             = 11;
  localparam int OUT_MAX           = 2047;
  localparam int POSITIONS_DEFAULT = 1024;

  localparam logic [1:0] CMD_CLEAR = 2'd0;
  localparam logic [1:0] CMD_MARK  = 2'd1;
  localparam logic [1:0] CMD_QUERY = 2'd2;

  function automatic logic [BIT_W:0] popcount(input logic [WORD_W-1:0] w);
    logic [BIT_W:0] s;
    s = '0;
    for (int i = 0; i < WORD_W; i++) begin
      s = s + (BIT_W + 1)'(w[i]);
    end
    return s;
  endfunction

endpackage

// File: sv/index_remap_after_edits.sv
// Index remap after edits: a bitmap of marked positions with rank/select queries.
// Commands arrive on start/cmd/position and are taken when start is high and busy
// is low. Clear (cmd 0) sweeps the bitmap memory one 32-bit row per cycle.
// Mark (cmd 1) is a read-modify-write of one row. cmd 3 and out-of-range marks
// are taken and dropped at once.
// Query (cmd 2) gives one result on mapped_index/removed, marked by done for exactly
// one cycle. Removal mode (remap_mode 0) streams rows 0 up to the row of the index
// through the popcount, one row per cycle. Insertion mode streams rows until the one
// holding the wanted zero, then shifts that row out one bit per cycle. The next
// command may be issued in the cycle done is high. remap_mode is written by
// cfg_we/cfg_wdata; the user must write it only while the block is idle, which
// the block itself does not enforce. Reset clears remap_mode and runs the
// clearing sweep, busy for the same length as a clear command. The receiver
// cannot stall: every result is shown once.
`include "index_remap_after_edits_defines.svh"

module index_remap_after_edits
  import irae_pkg::*;
#(
  parameter int POSITIONS = POSITIONS_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic             cfg_wdata,
  input  logic             start,
  input  logic [1:0]       cmd,
  input  logic [POS_W-1:0] position,
  output logic             busy,
  output logic             done,
  output logic [OUT_W-1:0] mapped_index,
  output logic             removed
);

  localparam int ROWS  = (POSITIONS + WORD_W - 1) / WORD_W;
  localparam int ROW_W = ROWS > 1 ? $clog2(ROWS) : 1;
  localparam int CNT_W = ($clog2(POSITIONS + 1) > POS_W ? $clog2(POSITIONS + 1) : POS_W) + 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CLR  = 3'd1;
  localparam logic [2:0] S_MRD  = 3'd2;
  localparam logic [2:0] S_MWR  = 3'd3;
  localparam logic [2:0] S_SCAN = 3'd4;
  localparam logic [2:0] S_BITS = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  logic [2:0]        state;
  logic              remap_mode;
  logic [ROW_W-1:0]  clr_row;
  logic [POS_W-1:0]  q_pos;
  logic              q_mode;
  logic              q_inrow;
  logic              q_removed;
  logic [ROW_W-1:0]  issue_row;
  logic              issue_on;
  logic [ROW_W-1:0]  last_row;
  logic              dvalid;
  logic              d_last;
  logic [CNT_W-1:0]  tally;
  logic [CNT_W-1:0]  base;
  logic [WORD_W-1:0] sr;

  // bitmap memory
  logic [WORD_W-1:0] mem [ROWS];
  logic [WORD_W-1:0] rd_data;
  logic              rd_en;
  logic [ROW_W-1:0]  rd_addr;
  logic              wr_en;
  logic [ROW_W-1:0]  wr_addr;
  logic [WORD_W-1:0] wr_data;

  logic [31:0]       in_row32;
  logic [31:0]       q_row32;
  logic              row_ok;
  logic              mark_ok;
  logic [WORD_W-1:0] mask;
  logic [BIT_W:0]    pc;
  logic [BIT_W:0]    zr;
  logic [CNT_W-1:0]  pos_ext;
  logic [CNT_W-1:0]  tally_plus_z;
  logic              hit;
  logic [CNT_W-1:0]  rem_val;
  logic [CNT_W-1:0]  ins_val;
  logic [CNT_W-1:0]  res_val;

  assign busy = (state != S_IDLE);

  assign in_row32 = 32'(position[POS_W-1:BIT_W]);
  assign q_row32  = 32'(q_pos[POS_W-1:BIT_W]);
  assign row_ok   = in_row32 < 32'(ROWS);
  assign mark_ok  = 32'(position) < 32'(POSITIONS);

  assign rd_en   = (state == S_MRD) || (state == S_SCAN && issue_on);
  assign rd_addr = (state == S_MRD) ? q_row32[ROW_W-1:0] : issue_row;
  assign wr_en   = (state == S_CLR) || (state == S_MWR);
  assign wr_addr = (state == S_CLR) ? clr_row : q_row32[ROW_W-1:0];
  assign wr_data = (state == S_CLR) ? '0
                 : (rd_data | (WORD_W'(1) << q_pos[BIT_W-1:0]));

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // keep bits at or below the index on the index's own row (removal rank)
  assign mask = (q_inrow && d_last)
              ? ({WORD_W{1'b1}} >> (BIT_W'(WORD_W - 1) - q_pos[BIT_W-1:0]))
              : {WORD_W{1'b1}};
  assign pc           = popcount(q_mode ? rd_data : (rd_data & mask));
  assign zr           = (BIT_W + 1)'(WORD_W) - pc;
  assign pos_ext      = CNT_W'(q_pos);
  assign tally_plus_z = tally + CNT_W'(zr);
  assign hit          = tally_plus_z > pos_ext;

  // insertion: base tracks the bit position, tally the zeros passed; once the
  // zero is found tally equals the index, so one formula covers both exits
  assign rem_val = (pos_ext >= tally) ? (pos_ext - tally) : '0;
  assign ins_val = base + (pos_ext - tally);
  assign res_val = q_mode ? ins_val : rem_val;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLR;
      clr_row    <= '0;
      remap_mode <= 1'b0;
      done       <= 1'b0;
      issue_on   <= 1'b0;
      dvalid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        remap_mode <= cfg_wdata;
      end
      done <= (state == S_OUT);
      case (state)
        S_IDLE: begin
          if (start) begin
            case (cmd)
              CMD_CLEAR: begin
                clr_row <= '0;
                state   <= S_CLR;
              end
              CMD_MARK: begin
                q_pos <= position;
                if (mark_ok) begin
                  state <= S_MRD;
                end
              end
              CMD_QUERY: begin
                q_pos     <= position;
                q_mode    <= remap_mode;
                q_inrow   <= row_ok;
                last_row  <= (!remap_mode && row_ok) ? in_row32[ROW_W-1:0]
                                                     : ROW_W'(ROWS - 1);
                issue_row <= '0;
                issue_on  <= 1'b1;
                dvalid    <= 1'b0;
                tally     <= '0;
                base      <= '0;
                q_removed <= 1'b0;
                state     <= S_SCAN;
              end
              default: begin
              end
            endcase
          end
        end
        S_CLR: begin
          clr_row <= clr_row + 1'b1;
          if (clr_row == ROW_W'(ROWS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_MRD: begin
          state <= S_MWR;
        end
        S_MWR: begin
          state <= S_IDLE;
        end
        S_SCAN: begin
          if (issue_on) begin
            issue_row <= issue_row + 1'b1;
            if (issue_row == last_row) begin
              issue_on <= 1'b0;
            end
          end
          dvalid <= issue_on;
          d_last <= (issue_row == last_row);
          if (dvalid) begin
            if (!q_mode) begin
              tally <= tally + CNT_W'(pc);
              if (d_last) begin
                q_removed <= q_inrow && rd_data[q_pos[BIT_W-1:0]];
                state     <= S_OUT;
              end
            end else if (hit) begin
              sr    <= rd_data;
              state <= S_BITS;
            end else begin
              tally <= tally_plus_z;
              base  <= base + CNT_W'(WORD_W);
              if (d_last) begin
                state <= S_OUT;
              end
            end
          end
        end
        S_BITS: begin
          sr <= sr >> 1;
          if (sr[0]) begin
            base <= base + 1'b1;
          end else if (tally == pos_ext) begin
            state <= S_OUT;
          end else begin
            tally <= tally + 1'b1;
            base  <= base + 1'b1;
          end
        end
        S_OUT: begin
          mapped_index <= (res_val > CNT_W'(OUT_MAX)) ? OUT_W'(OUT_MAX)
                                                      : res_val[OUT_W-1:0];
          removed      <= q_removed;
          state        <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `IRAE_ASSERT_SAME(a_done_idle, clk, rst, done, !busy, "result strobe while busy")
  `IRAE_ASSERT_NEXT(a_done_pulse, clk, rst, done, !done, "result strobe longer than one cycle")
  `IRAE_ASSERT_NEXT(a_query_busy, clk, rst, start && !busy && cmd == CMD_QUERY, busy, "query not started")
  `IRAE_ASSERT_SAME(a_removed_mode, clk, rst, done && removed, !q_mode, "removed flag in insertion mode")

endmodule

// File: bench/testbench.sv
module testbench
  import irae_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] CMD_IGNORED    = 2'd3;
  localparam logic       MODE_REMOVAL   = 1'b0;
  localparam logic       MODE_INSERTION = 1'b1;
  localparam int         SETTLE_CYCLES  = 40;
  localparam int         CYCLE_LIMIT    = 400000;
  localparam int         RANDOM_ITEMS   = 1030;

  typedef struct packed {
    logic [OUT_W-1:0] mapped_index;
    logic             removed;
  } remap_t;

  logic             clk;
  logic             rst;
  logic             cfg_we;
  logic             cfg_wdata;
  logic             start;
  logic [1:0]       cmd;
  logic [POS_W-1:0] position;
  logic             busy;
  logic             done;
  logic [OUT_W-1:0] mapped_index;
  logic             removed;

  // local copy of the block state
  bit [POSITIONS_DEFAULT-1:0] mark_map;
  logic                       remap_mode_q;
  remap_t                     pending_remaps[$];

  int idle_pct;
  int item_count;
  int mismatch_count;
  int cycle_count;
  int results_seen;
  int removal_queries;
  int insertion_queries;
  int marks_sent;
  int clears_sent;
  int ignored_sent;

  index_remap_after_edits dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .start       (start),
    .cmd         (cmd),
    .position    (position),
    .busy        (busy),
    .done        (done),
    .mapped_index(mapped_index),
    .removed     (removed)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_remaps.size());
      $display("Mismatches found");
      $finish;
    end
  end

  // Where the old index lands after the edits in the bitmap.
  function automatic remap_t remap_index(input logic [POS_W-1:0] pos);
    remap_t r;
    int     rank;
    int     zeros;
    int     n;
    r = '0;
    if (remap_mode_q == MODE_REMOVAL) begin
      rank = 0;
      for (int i = 0; i <= int'(pos); i++) begin
        if (mark_map[i]) rank++;
      end
      // everything at and below the index removed: pin at zero
      r.mapped_index = (int'(pos) >= rank) ? OUT_W'(int'(pos) - rank) : '0;
      r.removed      = mark_map[pos];
    end else begin
      // select of zeros; past the bitmap everything is unmarked
      zeros = 0;
      n     = 0;
      while (1) begin
        if (n < POSITIONS_DEFAULT && mark_map[n]) begin
          n++;
        end else if (zeros == int'(pos)) begin
          break;
        end else begin
          zeros++;
          n++;
        end
      end
      r.mapped_index = (n > OUT_MAX) ? OUT_W'(OUT_MAX) : OUT_W'(n);
      r.removed      = 1'b0;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    remap_t exp_r;
    if (!rst && done) begin
      results_seen++;
      if (pending_remaps.size() == 0) begin
        $error("Unexpected result: mapped_index %0d removed %0d", mapped_index, removed);
        mismatch_count++;
      end else begin
        exp_r = pending_remaps.pop_front();
        if (mapped_index !== exp_r.mapped_index) begin
          $error("mapped_index: expected %0d, actual %0d", exp_r.mapped_index,
                 mapped_index);
          mismatch_count++;
        end
        if (removed !== exp_r.removed) begin
          $error("removed: expected %0d, actual %0d", exp_r.removed, removed);
          mismatch_count++;
        end
      end
    end
  end

  task automatic send_item(input logic [1:0] c, input logic [POS_W-1:0] p);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start    <= 1'b1;
    cmd      <= c;
    position <= p;
    do @(posedge clk); while (busy);
    // transaction taken at this edge
    case (c)
      CMD_CLEAR: begin
        mark_map = '0;
        clears_sent++;
      end
      CMD_MARK: begin
        mark_map[p] = 1'b1;
        marks_sent++;
      end
      CMD_QUERY: begin
        pending_remaps.insert(pending_remaps.size(), remap_index(p));
        if (remap_mode_q == MODE_REMOVAL) removal_queries++;
        else insertion_queries++;
      end
      default: ignored_sent++;
    endcase
    if (c != CMD_IGNORED) item_count++;
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    while (pending_remaps.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_remap_mode(input logic m);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_we    <= 1'b0;
    remap_mode_q = m;
  endtask

  task automatic test_empty_bitmap();
    send_item(CMD_QUERY, '0);
    send_item(CMD_QUERY, '1);
    send_item(CMD_IGNORED, '1);
    send_item(CMD_IGNORED, '0);
  endtask

  task automatic test_removal_mode();
    set_remap_mode(MODE_REMOVAL);
    send_item(CMD_MARK, 10'd0);
    send_item(CMD_MARK, 10'd1);
    send_item(CMD_MARK, 10'd2);
    send_item(CMD_MARK, 10'd1023);
    send_item(CMD_MARK, 10'd1);
    send_item(CMD_QUERY, 10'd2);
    send_item(CMD_QUERY, 10'd3);
    send_item(CMD_QUERY, 10'd1023);
    send_item(CMD_QUERY, 10'd512);
  endtask

  task automatic test_insertion_mode();
    set_remap_mode(MODE_INSERTION);
    send_item(CMD_QUERY, 10'd0);
    send_item(CMD_QUERY, 10'd1019);
    send_item(CMD_QUERY, 10'd1023);
    send_item(CMD_CLEAR, 10'd0);
    send_item(CMD_QUERY, 10'd5);
    send_item(CMD_QUERY, 10'd1023);
  endtask

  // Mostly clear, a burst of marks near one spot, then queries around it.
  task automatic run_session();
    int               style;
    int               span;
    int               sel;
    logic [POS_W-1:0] base;
    logic [POS_W-1:0] p;
    style = $urandom_range(0, 9);
    if (style < 8) begin
      if ($urandom_range(0, 4) != 0) send_item(CMD_CLEAR, POS_W'($urandom));
      case ($urandom_range(0, 2))
        0: span = 8;
        1: span = 64;
        default: span = 1024;
      endcase
      base = ($urandom_range(0, 3) == 0) ? '0 : POS_W'($urandom);
      repeat ($urandom_range(0, 24)) begin
        send_item(CMD_MARK, base + POS_W'($urandom_range(0, span - 1)));
      end
      repeat ($urandom_range(1, 8)) begin
        sel = $urandom_range(0, 9);
        if (sel < 5) p = base + POS_W'($urandom_range(0, span + 3));
        else if (sel < 8) p = POS_W'($urandom);
        else if (sel == 8) p = '0;
        else p = '1;
        if ($urandom_range(0, 19) == 0) send_item(CMD_IGNORED, POS_W'($urandom));
        send_item(CMD_QUERY, p);
      end
    end else begin
      repeat ($urandom_range(1, 6)) send_item(2'($urandom), POS_W'($urandom));
    end
  endtask

  task automatic test_random_traffic();
    // receiver stalls cannot happen here; phases 0 and 2 send without idling
    int pct_by_phase[4] = '{0, 58, 0, 36};
    int target;
    for (int ph = 0; ph < 4; ph++) begin
      for (int m = 0; m < 2; m++) begin
        set_remap_mode(m[0] ^ ph[0]);
        idle_pct = pct_by_phase[ph];
        target   = item_count + RANDOM_ITEMS / 8;
        while (item_count < target) run_session();
      end
    end
    idle_pct = 0;
  endtask

  initial begin
    rst       <= 1'b1;
    start     <= 1'b0;
    cmd       <= CMD_CLEAR;
    position  <= '0;
    cfg_we    <= 1'b0;
    cfg_wdata <= 1'b0;
    mark_map     = '0;
    remap_mode_q = MODE_REMOVAL;
    idle_pct     = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    test_empty_bitmap();
    test_removal_mode();
    test_insertion_mode();
    test_random_traffic();
    wait_idle();

    $display("Checked %0d query results (%0d removal, %0d insertion) in %0d cycles",
             results_seen, removal_queries, insertion_queries, cycle_count);
    $display("Stimulus: %0d marks, %0d clears, %0d ignored commands, sender idle 0/58/36 pct",
             marks_sent, clears_sent, ignored_sent);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
